// ----- rtl/core/sts_pkg.sv -----
// Shared types and constants for the step timeline sequencer.
`default_nettype none
package sts_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam int TICK_W        = 10;
    localparam int DUR_W         = 24;
    localparam int ELAP_W        = 25;
    localparam int POS_W         = 30;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam logic [TICK_W-1:0] TICK_RST = 10'd10;
    localparam logic [31:0] TOTAL_MAX = 32'h3FFF_FFFF;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_LOAD    = 3'd1;
    localparam logic [2:0] KIND_REPLACE = 3'd2;
    localparam logic [2:0] KIND_PLAY    = 3'd3;
    localparam logic [2:0] KIND_PAUSE   = 3'd4;
    localparam logic [2:0] KIND_STOP    = 3'd5;
    localparam logic [2:0] KIND_SEEK    = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ARG   = 2'd1;
    localparam logic [1:0] ST_STATE = 2'd2;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_APPLY     = 3'd1;
    localparam logic [2:0] EV_APPLY_OFS = 3'd2;
    localparam logic [2:0] EV_PAUSE     = 3'd3;
    localparam logic [2:0] EV_OFF       = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK, OP_LOAD, OP_REPLACE, OP_PLAY, OP_PAUSE, OP_STOP, OP_SEEK, OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_EXEC, BK_SEEK, BK_SUM_INIT, BK_SUM, BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] entry_idx;
        logic [DUR_W-1:0] entry_dur;
        logic             last_step;
        logic [POS_W-1:0] seek_pos;
    } seq_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        event_res;
        logic [IDX_W-1:0]  event_step;
        logic [DUR_W-1:0]  event_offset_ms;
        logic              playing;
        logic              paused;
        logic              realtime_res;
        logic [IDX_W-1:0]  current_step;
        logic [ELAP_W-1:0] elapsed_ms;
        logic [POS_W-1:0]  total_elapsed_ms;
        logic [CNT_W-1:0]  num_steps;
    } seq_rsp_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] entry_idx;
        logic [DUR_W-1:0] entry_dur;
        logic             last_step;
        logic [POS_W-1:0] seek_pos;
    } seq_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/sts_front.sv -----
// Front end: decodes requests and queues them for the back end.
`default_nettype none
module sts_front
    import sts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire seq_req_t  req,
    output logic           item_valid,
    output seq_item_t      item,
    input  wire logic      item_pop
);

    seq_item_t  q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    seq_item_t  dec;
    logic       push, pop;

    always_comb
    begin
        dec.entry_idx = req.entry_idx;
        dec.entry_dur = req.entry_dur;
        dec.last_step = req.last_step;
        dec.seek_pos  = req.seek_pos;
        case (req.kind)
            KIND_TICK:    dec.op = OP_TICK;
            KIND_LOAD:    dec.op = OP_LOAD;
            KIND_REPLACE: dec.op = OP_REPLACE;
            KIND_PLAY:    dec.op = OP_PLAY;
            KIND_PAUSE:   dec.op = OP_PAUSE;
            KIND_STOP:    dec.op = OP_STOP;
            KIND_SEEK:    dec.op = OP_SEEK;
            default:      dec.op = OP_BAD;
        endcase
    end

    assign busy       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];
    assign push       = start && !busy;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/sts_back.sv -----
// Back end: executes commands, walks the step table, forms results.
`default_nettype none
module sts_back
    import sts_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [TICK_W-1:0] tick_ms,
    input  wire logic              item_valid,
    input  wire seq_item_t         item,
    output logic                   item_pop,
    output logic                   done,
    output seq_rsp_t               rsp
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [31:0] MAX_W = 32'(MAX_STEPS);

    logic [DUR_W-1:0] mem [MAX_STEPS];
    logic [DUR_W-1:0] rdata_reg;
    logic [CNT_W-1:0] rd_idx;
    logic             wr_en;

    bk_state_t         state_reg, state_next;
    seq_item_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [ELAP_W-1:0] elap_reg, elap_next;
    logic              play_reg, play_next;
    logic              pause_reg, pause_next;
    logic              rt_reg, rt_next;
    logic              zs_reg, zs_next;
    logic [1:0]        status_reg, status_next;
    logic [2:0]        ev_reg, ev_next;
    logic [IDX_W-1:0]  evs_reg, evs_next;
    logic [DUR_W-1:0]  evo_reg, evo_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [30:0]       acc_reg, acc_next;
    logic [POS_W-1:0]  total_reg, total_next;

    logic              idx_bad;
    logic [ELAP_W-1:0] tick_sum;
    logic              zs;
    logic              rt;
    logic [31:0]       acc_end;
    logic [31:0]       tot;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(cmd_reg.entry_idx)] <= cmd_reg.entry_dur;
        end
        rdata_reg <= mem[AW'(rd_idx)];
    end

    assign idx_bad  = ({26'd0, cmd_reg.entry_idx} >= MAX_W);
    assign tick_sum = elap_reg + {15'd0, tick_ms};
    assign zs       = zs_reg || (cmd_reg.entry_dur == '0);
    assign rt       = (cmd_reg.entry_idx == '0) && (cmd_reg.entry_dur == '0);
    assign acc_end  = {1'b0, acc_reg} + {8'd0, rdata_reg};
    assign tot      = {1'b0, acc_reg} + {7'd0, elap_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cmd_reg.op == OP_SEEK && !rt_reg)
                begin
                    state_next = BK_SEEK;
                end
                else
                begin
                    state_next = BK_SUM_INIT;
                end
            end
            BK_SEEK:
            begin
                if (i_reg >= count_reg || {1'b0, cmd_reg.seek_pos} < acc_end[30:0]
                    || {1'b0, cmd_reg.seek_pos} < acc_reg)
                begin
                    state_next = BK_SUM_INIT;
                end
            end
            BK_SUM_INIT: state_next = BK_SUM;
            BK_SUM:
            begin
                if (!(i_reg < {1'b0, cur_reg} && i_reg < count_reg))
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:  state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        item_pop = (state_reg == BK_IDLE) && item_valid;
        done     = (state_reg == BK_OUT);
        wr_en    = (state_reg == BK_EXEC) && !idx_bad
                   && ((cmd_reg.op == OP_LOAD)
                       || (cmd_reg.op == OP_REPLACE
                           && {1'b0, cmd_reg.entry_idx} < count_reg
                           && (rt_reg || cmd_reg.entry_dur != '0)));
        case (state_reg)
            BK_IDLE: rd_idx = {1'b0, cur_reg};
            BK_SEEK: rd_idx = 7'(i_reg + 7'd1);
            BK_SUM:  rd_idx = 7'(i_reg + 7'd1);
            default: rd_idx = '0;
        endcase
        rsp.status           = status_reg;
        rsp.event_res        = ev_reg;
        rsp.event_step       = evs_reg;
        rsp.event_offset_ms  = evo_reg;
        rsp.playing          = play_reg;
        rsp.paused           = pause_reg;
        rsp.realtime_res     = rt_reg;
        rsp.current_step     = cur_reg;
        rsp.elapsed_ms       = elap_reg;
        rsp.total_elapsed_ms = total_reg;
        rsp.num_steps        = count_reg;
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        elap_next   = elap_reg;
        play_next   = play_reg;
        pause_next  = pause_reg;
        rt_next     = rt_reg;
        zs_next     = zs_reg;
        status_next = status_reg;
        ev_next     = ev_reg;
        evs_next    = evs_reg;
        evo_next    = evo_reg;
        i_next      = i_reg;
        acc_next    = acc_reg;
        total_next  = total_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next    = item;
                    status_next = ST_OK;
                    ev_next     = EV_NONE;
                    evs_next    = '0;
                    evo_next    = '0;
                end
            end
            BK_EXEC:
            begin
                i_next   = '0;
                acc_next = '0;
                case (cmd_reg.op)
                    OP_TICK:
                    begin
                        if (play_reg && count_reg != '0 && !rt_reg)
                        begin
                            if (tick_sum >= {1'b0, rdata_reg})
                            begin
                                elap_next = '0;
                                if ({1'b0, cur_reg} + 7'd1 < count_reg)
                                begin
                                    cur_next = cur_reg + 6'd1;
                                    ev_next  = EV_APPLY;
                                    evs_next = cur_reg + 6'd1;
                                end
                                else
                                begin
                                    play_next = 1'b0;
                                    cur_next  = '0;
                                    ev_next   = EV_OFF;
                                end
                            end
                            else
                            begin
                                elap_next = tick_sum;
                            end
                        end
                    end
                    OP_LOAD:
                    begin
                        if (idx_bad)
                        begin
                            status_next = ST_ARG;
                        end
                        else
                        begin
                            play_next  = 1'b0;
                            pause_next = 1'b0;
                            zs_next    = zs;
                            if (cmd_reg.last_step)
                            begin
                                cur_next  = '0;
                                elap_next = '0;
                                zs_next   = 1'b0;
                                if (!rt && zs)
                                begin
                                    status_next = ST_ARG;
                                    count_next  = '0;
                                    rt_next     = 1'b0;
                                end
                                else
                                begin
                                    count_next = {1'b0, cmd_reg.entry_idx} + 7'd1;
                                    rt_next    = rt;
                                end
                            end
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (idx_bad || {1'b0, cmd_reg.entry_idx} >= count_reg
                            || (!rt_reg && cmd_reg.entry_dur == '0))
                        begin
                            status_next = ST_ARG;
                        end
                        else
                        begin
                            if (rt_reg && count_reg == 7'd1)
                            begin
                                rt_next = rt;
                            end
                            if (cmd_reg.entry_idx == cur_reg)
                            begin
                                ev_next  = EV_APPLY;
                                evs_next = cmd_reg.entry_idx;
                            end
                        end
                    end
                    OP_PLAY:
                    begin
                        if (count_reg != '0 && !play_reg)
                        begin
                            if ({1'b0, cur_reg} >= count_reg)
                            begin
                                status_next = ST_ARG;
                            end
                            else
                            begin
                                ev_next    = EV_APPLY_OFS;
                                evs_next   = cur_reg;
                                evo_next   = elap_reg[DUR_W-1:0];
                                play_next  = 1'b1;
                                pause_next = 1'b0;
                            end
                        end
                    end
                    OP_PAUSE:
                    begin
                        if (rt_reg)
                        begin
                            status_next = ST_STATE;
                        end
                        else
                        begin
                            pause_next = play_reg;
                            play_next  = 1'b0;
                            if (play_reg)
                            begin
                                ev_next = EV_PAUSE;
                            end
                        end
                    end
                    OP_STOP:
                    begin
                        play_next  = 1'b0;
                        pause_next = 1'b0;
                        rt_next    = 1'b0;
                        cur_next   = '0;
                        elap_next  = '0;
                        ev_next    = EV_OFF;
                    end
                    OP_SEEK:
                    begin
                        if (rt_reg)
                        begin
                            status_next = ST_STATE;
                        end
                    end
                    default: status_next = ST_ARG;
                endcase
            end
            BK_SEEK:
            begin
                if (i_reg >= count_reg)
                begin
                    status_next = ST_ARG;
                end
                else if ({1'b0, cmd_reg.seek_pos} >= acc_reg
                         && {2'b0, cmd_reg.seek_pos} < acc_end)
                begin
                    cur_next  = i_reg[IDX_W-1:0];
                    elap_next = 25'({1'b0, cmd_reg.seek_pos} - acc_reg);
                    if (play_reg || pause_reg)
                    begin
                        ev_next  = EV_APPLY_OFS;
                        evs_next = i_reg[IDX_W-1:0];
                        evo_next = 24'({1'b0, cmd_reg.seek_pos} - acc_reg);
                    end
                end
                else
                begin
                    acc_next = acc_end[30:0];
                    i_next   = i_reg + 7'd1;
                end
            end
            BK_SUM_INIT:
            begin
                i_next   = '0;
                acc_next = '0;
            end
            BK_SUM:
            begin
                if (i_reg < {1'b0, cur_reg} && i_reg < count_reg)
                begin
                    acc_next = acc_end[30:0];
                    i_next   = i_reg + 7'd1;
                end
                else
                begin
                    total_next = (tot > TOTAL_MAX) ? TOTAL_MAX[POS_W-1:0] : tot[POS_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            count_reg  <= '0;
            cur_reg    <= '0;
            elap_reg   <= '0;
            play_reg   <= 1'b0;
            pause_reg  <= 1'b0;
            rt_reg     <= 1'b0;
            zs_reg     <= 1'b0;
            status_reg <= ST_OK;
            ev_reg     <= EV_NONE;
            evs_reg    <= '0;
            evo_reg    <= '0;
            i_reg      <= '0;
            acc_reg    <= '0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            elap_reg   <= elap_next;
            play_reg   <= play_next;
            pause_reg  <= pause_next;
            rt_reg     <= rt_next;
            zs_reg     <= zs_next;
            status_reg <= status_next;
            ev_reg     <= ev_next;
            evs_reg    <= evs_next;
            evo_reg    <= evo_next;
            i_reg      <= i_next;
            acc_reg    <= acc_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/step_timeline_sequencer.sv -----
// Top level of the step timeline sequencer.
// Usage:
//   A request (req) is taken on a clock edge with start high and busy low.
//   Requests enter a two-entry queue; busy is high while the queue is full.
//   Each request gives one result on rsp, valid for exactly one cycle with
//   done high. The receiver cannot stall; results come out in request order.
//   Each request passes through the states EXEC, SUM_INIT, SUM and OUT;
//   SUM adds up the durations of the steps before the cursor step to
//   form total_elapsed_ms. A seek, unless realtime_res is set, first
//   walks the table in SEEK, entry by entry from the first, until it
//   reaches the target step or the end of the table. A queued request
//   also waits for the one ahead of it. The step table is read one
//   entry per cycle. tick_ms is written with cfg_we/cfg_data; the user
//   must write it only while no request is pending (not enforced).
//   Reset clears the cursor, flags, step count and tick_ms (to 10); the
//   table contents are undefined until loaded.
`default_nettype none
module step_timeline_sequencer
    import sts_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire seq_req_t          req,
    output logic                   done,
    output seq_rsp_t               rsp,
    input  wire logic              cfg_we,
    input  wire logic [TICK_W-1:0] cfg_data
);

    logic [TICK_W-1:0] tick_reg;
    logic              item_valid;
    logic              item_pop;
    seq_item_t         item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= TICK_RST;
        end
        else if (cfg_we)
        begin
            tick_reg <= cfg_data;
        end
    end

    sts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    sts_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_ms    (tick_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .done       (done),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the step timeline sequencer: directed and random requests.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import sts_pkg::*;

    class seq_scoreboard;
        logic [DUR_W-1:0] dur_tbl [64];
        bit               written [64];
        int unsigned      cnt, cur, elap;
        bit               play, pause, rt, zseen;
        logic [TICK_W-1:0] tick_ms;
        seq_rsp_t         exp_q [$];
        int               errors;

        function new();
            tick_ms = TICK_RST;
            errors  = 0;
            cnt = 0; cur = 0; elap = 0;
            play = 0; pause = 0; rt = 0; zseen = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function longint seq_len();
            longint s;
            s = 0;
            for (int i = 0; i < cnt; i++) s += dur_tbl[i];
            return s;
        endfunction

        function bit prefix_ok(int idx);
            for (int i = 0; i < idx; i++)
                if (!written[i]) return 0;
            return 1;
        endfunction

        function void note(seq_req_t r);
            seq_rsp_t o;
            longint   acc, t;
            bit       found;
            bit       rtl;
            int       idx;
            o = '0;
            idx = r.entry_idx;
            o.status = ST_OK;
            o.event_res = EV_NONE;
            case (op_t'(r.kind))
                OP_TICK:
                    if (play && cnt != 0 && !rt) begin
                        elap += tick_ms;
                        if (elap >= dur_tbl[cur]) begin
                            if (cur + 1 < cnt) begin
                                cur++;
                                elap = 0;
                                o.event_res = EV_APPLY;
                                o.event_step = IDX_W'(cur);
                            end else begin
                                play = 0; cur = 0; elap = 0;
                                o.event_res = EV_OFF;
                            end
                        end
                    end
                OP_LOAD: begin
                    play = 0;
                    pause = 0;
                    dur_tbl[idx] = r.entry_dur;
                    written[idx] = 1;
                    if (r.entry_dur == 0) zseen = 1;
                    if (r.last_step) begin
                        rtl = (idx == 0 && r.entry_dur == 0);
                        cur = 0;
                        elap = 0;
                        if (!rtl && zseen) begin
                            o.status = ST_ARG;
                            cnt = 0;
                            rt = 0;
                        end else begin
                            cnt = idx + 1;
                            rt = rtl;
                        end
                        zseen = 0;
                    end
                end
                OP_REPLACE:
                    if (idx >= cnt || (!rt && r.entry_dur == 0)) o.status = ST_ARG;
                    else begin
                        dur_tbl[idx] = r.entry_dur;
                        if (rt && cnt == 1) rt = (idx == 0 && r.entry_dur == 0);
                        if (idx == cur) begin
                            o.event_res = EV_APPLY;
                            o.event_step = IDX_W'(idx);
                        end
                    end
                OP_PLAY:
                    if (cnt != 0 && !play) begin
                        if (cur >= cnt) o.status = ST_ARG;
                        else begin
                            o.event_res = EV_APPLY_OFS;
                            o.event_step = IDX_W'(cur);
                            o.event_offset_ms = elap[DUR_W-1:0];
                            play = 1;
                            pause = 0;
                        end
                    end
                OP_PAUSE:
                    if (rt) o.status = ST_STATE;
                    else begin
                        pause = play;
                        if (play) o.event_res = EV_PAUSE;
                        play = 0;
                    end
                OP_STOP: begin
                    play = 0; pause = 0; rt = 0; cur = 0; elap = 0;
                    o.event_res = EV_OFF;
                end
                OP_SEEK:
                    if (rt) o.status = ST_STATE;
                    else begin
                        acc = 0;
                        found = 0;
                        for (int i = 0; i < cnt && !found; i++) begin
                            if (r.seek_pos >= acc && r.seek_pos < acc + dur_tbl[i]) begin
                                cur = i;
                                elap = 32'(r.seek_pos - acc);
                                found = 1;
                            end
                            acc += dur_tbl[i];
                        end
                        if (!found) o.status = ST_ARG;
                        else if (play || pause) begin
                            o.event_res = EV_APPLY_OFS;
                            o.event_step = IDX_W'(cur);
                            o.event_offset_ms = elap[DUR_W-1:0];
                        end
                    end
                default: o.status = ST_ARG;
            endcase
            t = elap;
            for (int i = 0; i < cur && i < cnt; i++) t += dur_tbl[i];
            if (t > TOTAL_MAX) t = TOTAL_MAX;
            o.playing = play;
            o.paused = pause;
            o.realtime_res = rt;
            o.current_step = IDX_W'(cur);
            o.elapsed_ms = ELAP_W'(elap);
            o.total_elapsed_ms = POS_W'(t);
            o.num_steps = CNT_W'(cnt);
            exp_q.push_back(o);
        endfunction

        function void check(seq_rsp_t a);
            seq_rsp_t e;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", a);
                return;
            end
            e = exp_q.pop_front();
            if (a.status !== e.status || a.event_res !== e.event_res
                || a.event_step !== e.event_step || a.event_offset_ms !== e.event_offset_ms
                || a.playing !== e.playing || a.paused !== e.paused
                || a.realtime_res !== e.realtime_res || a.current_step !== e.current_step
                || a.elapsed_ms !== e.elapsed_ms || a.total_elapsed_ms !== e.total_elapsed_ms
                || a.num_steps !== e.num_steps) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at %0t", $time);
                    $display("  exp st=%0d ev=%0d es=%0d eo=%0d p=%b ps=%b rt=%b cs=%0d el=%0d tot=%0d n=%0d",
                        e.status, e.event_res, e.event_step, e.event_offset_ms, e.playing,
                        e.paused, e.realtime_res, e.current_step, e.elapsed_ms,
                        e.total_elapsed_ms, e.num_steps);
                    $display("  got st=%0d ev=%0d es=%0d eo=%0d p=%b ps=%b rt=%b cs=%0d el=%0d tot=%0d n=%0d",
                        a.status, a.event_res, a.event_step, a.event_offset_ms, a.playing,
                        a.paused, a.realtime_res, a.current_step, a.elapsed_ms,
                        a.total_elapsed_ms, a.num_steps);
                end
            end
        endfunction
    endclass

    logic              clk, rst_n, start, busy, done, cfg_we;
    logic [TICK_W-1:0] cfg_data;
    seq_req_t          req;
    seq_rsp_t          rsp;
    seq_scoreboard     sb;
    int                sent;
    bit                quiet;

    step_timeline_sequencer uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && done) sb.check(rsp);

    task automatic send(seq_req_t r);
        req <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note(r);
        sent++;
    endtask

    task automatic pause_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) pause_cycles($urandom_range(1, 18));
    endtask

    function automatic seq_req_t make_req(logic [2:0] k, int idx, int dur, bit last, int pos);
        seq_req_t r;
        r = {$urandom, $urandom};
        r.kind = k;
        r.entry_idx = IDX_W'(idx);
        r.entry_dur = DUR_W'(dur);
        r.last_step = last;
        r.seek_pos = POS_W'(pos);
        return r;
    endfunction

    task automatic drain_and_write(logic [TICK_W-1:0] v);
        pause_cycles(1);
        while (sb.exp_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.tick_ms = v;
    endtask

    task automatic load_table(int n, bit zero_mode);
        int d;
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, 3) == 0 ? $urandom_range(1, 400) : $urandom_range(1, 60);
            if (zero_mode && $urandom_range(0, n - 1) == 0) d = 0;
            if ($urandom_range(0, 40) == 0) d = $urandom_range(1, 24'hFFFFFF);
            send(make_req(KIND_LOAD, i, d, i == n - 1, 0));
            maybe_gap();
        end
    endtask

    function automatic int pick_pos();
        longint len;
        len = sb.seq_len();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 30'h3FFFFFFF);
            1: return int'(len);
            default: return len == 0 ? 0 : $urandom_range(0, len - 1);
        endcase
    endfunction

    task automatic random_req();
        int r, idx;
        r = $urandom_range(0, 99);
        if (r < 45) send(make_req(KIND_TICK, 0, 0, 0, 0));
        else if (r < 50) begin
            idx = $urandom_range(0, 63);
            send(make_req(KIND_LOAD, idx, $urandom_range(0, 200) == 0 ? 0 : $urandom_range(1, 24'hFFFFFF),
                sb.prefix_ok(idx) && $urandom_range(0, 1), 0));
        end
        else if (r < 58) begin
            idx = (sb.cnt != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, sb.cnt - 1)
                                                           : $urandom_range(0, 63);
            send(make_req(KIND_REPLACE, idx, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 80), 0, 0));
        end
        else if (r < 66) send(make_req(KIND_PLAY, 0, 0, 0, 0));
        else if (r < 72) send(make_req(KIND_PAUSE, 0, 0, 0, 0));
        else if (r < 76) send(make_req(KIND_STOP, 0, 0, 0, 0));
        else if (r < 86) send(make_req(KIND_SEEK, 0, 0, 0, pick_pos()));
        else if (r < 88) send(make_req(3'(OP_BAD), 0, 0, 0, 0));
        else if (r < 90) begin
            send(make_req(KIND_LOAD, 0, 0, 1, 0));
        end
        else begin
            load_table($urandom_range(0, 12) == 0 ? 64 : $urandom_range(1, 8), $urandom_range(0, 7) == 0);
            send(make_req(KIND_PLAY, 0, 0, 0, 0));
        end
        maybe_gap();
    endtask

    initial
    begin
        logic [TICK_W-1:0] ticks [6];
        sb = new();
        sent = 0;
        quiet = 0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(make_req(KIND_LOAD, 0, 30, 0, 0));
        send(make_req(KIND_LOAD, 1, 20, 0, 0));
        send(make_req(KIND_LOAD, 2, 25, 1, 0));
        send(make_req(KIND_TICK, 0, 0, 0, 0));
        send(make_req(KIND_PLAY, 0, 0, 0, 0));
        repeat (4) send(make_req(KIND_TICK, 0, 0, 0, 0));
        send(make_req(KIND_SEEK, 0, 0, 0, 55));
        send(make_req(KIND_PAUSE, 0, 0, 0, 0));
        send(make_req(KIND_PAUSE, 0, 0, 0, 0));
        send(make_req(KIND_PLAY, 0, 0, 0, 0));
        send(make_req(KIND_REPLACE, 2, 40, 0, 0));
        send(make_req(KIND_REPLACE, 63, 40, 0, 0));
        send(make_req(KIND_REPLACE, 1, 0, 0, 0));
        send(make_req(KIND_SEEK, 0, 0, 0, 30'h3FFFFFFF));
        repeat (5) send(make_req(KIND_TICK, 0, 0, 0, 0));
        send(make_req(KIND_STOP, 0, 0, 0, 0));
        send(make_req(3'(OP_BAD), 0, 0, 0, 0));
        send(make_req(KIND_LOAD, 0, 0, 1, 0));
        send(make_req(KIND_PLAY, 0, 0, 0, 0));
        send(make_req(KIND_TICK, 0, 0, 0, 0));
        send(make_req(KIND_PAUSE, 0, 0, 0, 0));
        send(make_req(KIND_SEEK, 0, 0, 0, 0));
        send(make_req(KIND_REPLACE, 0, 5, 0, 0));
        send(make_req(KIND_LOAD, 0, 0, 0, 0));
        send(make_req(KIND_LOAD, 1, 5, 1, 0));
        send(make_req(KIND_LOAD, 0, 24'hFFFFFF, 1, 0));
        send(make_req(KIND_SEEK, 0, 0, 0, 24'hFFFFFE));

        ticks[0] = 10'd1;
        ticks[1] = 10'd1023;
        ticks[2] = 10'd0;
        ticks[3] = 10'd1000;
        ticks[4] = 10'($urandom_range(2, 40));
        ticks[5] = 10'($urandom_range(1, 1000));
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(ticks[ph]);
            quiet = (ph == 5);
            while (sent < 30 + (ph + 1) * 220) random_req();
        end

        start <= 1'b0;
        for (int i = 0; i < 2000 && sb.exp_q.size() != 0; i++) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.exp_q.size() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
